### src/hsl2rgb_pkg.sv
// Shared constants and types for the HSLA to RGBA color converter.
// No dependencies; imported by hsla_to_rgba_core.
package hsl2rgb_pkg;

    // Default fraction width of the internal fixed-point values
    localparam int FRAC_BITS_DEF = 16;

    // 65535 stands for one on every 16-bit field
    localparam logic [15:0] IO_ONE  = 16'hFFFF;
    localparam logic [15:0] IO_HALF = 16'h7FFF;

    // 65535^2, its rounding half, and 2^32 - 65535^2
    localparam logic [32:0] DEN      = 33'd4294836225;
    localparam logic [31:0] DEN_HALF = 32'd2147418112;
    localparam logic [16:0] DEN_GAP  = 17'd131071;

    // Hue sectors, one sixth of a turn each
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

### src/hsla_to_rgba_core.sv
// HSLA to RGBA color converter, seven-stage pipeline.
// Depends on hsl2rgb_pkg for constants and the hue sector type.
//
// Usage:
//   Input channel:  i_valid, i_hue, i_saturation, i_lightness, i_alpha_in,
//                   o_stall. A request is taken at a clock edge with i_valid
//                   high and o_stall low.
//   Output channel: o_valid, o_red, o_green, o_blue, o_alpha_out, i_stall.
//                   A result is taken at a clock edge with o_valid high and
//                   i_stall low.
//   A request passes through stage registers one to seven in order.
//   Throughput: one request per cycle when not stalled. Each stage has its
//   own valid bit and loads whenever it is empty or the stage after it
//   moves, so empty slots close up while the receiver stalls and new
//   requests keep entering until all seven stages are full. A stalled
//   result holds on the outputs.
//   Division by 65535 and 65535^2 is done with shift/add estimates and two
//   correction steps spread over stages two to four; stage one forms the
//   16x16 chroma product and stage five chroma times sector position.
//   Reset (synchronous, active low) clears all valid bits; data registers
//   are not reset. There is no configuration and no state between requests.
module hsla_to_rgba_core
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_hue,
    input  logic [15:0] i_saturation,
    input  logic [15:0] i_lightness,
    input  logic [15:0] i_alpha_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    output logic [15:0] o_alpha_out
);

    localparam int F     = FRAC_BITS;
    localparam int NW    = 33 + F;
    localparam int R0W   = (F + 17 > 32) ? F + 18 : 33;
    localparam int Q1W   = R0W - 32;
    localparam int LAW   = 17 + F;
    localparam int LRW   = ((F > 16) ? F : 16) + 1;
    localparam int LQ1W  = LRW - 16;
    localparam int CW    = F + 3;
    localparam int XPW   = F + 18;
    localparam int PW    = F + 19;
    localparam int NST   = 7;

    // to_channel: round v * 65535 / 2^(F+1), clamp to 0..65535
    function automatic logic [15:0] to_channel(input logic signed [CW-1:0] v);
        logic [PW-1:0] p;
        logic [PW-1:0] r;
        begin
            p = (PW'(unsigned'(v)) << 16) - PW'(unsigned'(v)) + (PW'(1) << F);
            r = p >> (F + 1);
            if (v <= 0) begin
                to_channel = 16'd0;
            end else if (r > PW'(IO_ONE)) begin
                to_channel = IO_ONE;
            end else begin
                to_channel = r[15:0];
            end
        end
    endfunction

    logic [NST:1] r_vld;
    logic [NST:1] w_adv;

    always_comb begin
        w_adv[NST] = !r_vld[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[1];
    assign o_valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: chroma product, hue sector ----------------
    logic [16:0] n_s1_twol;
    logic [15:0] n_s1_dist;
    logic [15:0] n_s1_t;
    logic [18:0] n_s1_h6;
    logic [31:0] n_s1_ts;
    logic [16:0] n_s1_w;

    logic [31:0] r_s1_ts;
    logic [15:0] r_s1_lig;
    t_sector     r_s1_sec;
    logic [16:0] r_s1_w;
    logic [15:0] r_s1_alp;

    always_comb begin
        n_s1_twol = {i_lightness, 1'b0};
        if (n_s1_twol >= {1'b0, IO_ONE}) begin
            n_s1_dist = 16'(n_s1_twol - {1'b0, IO_ONE});
        end else begin
            n_s1_dist = 16'({1'b0, IO_ONE} - n_s1_twol);
        end
        n_s1_t  = IO_ONE - n_s1_dist;
        n_s1_ts = n_s1_t * i_saturation;
        n_s1_h6 = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
        // odd sectors use the falling edge of the position
        if (n_s1_h6[16]) begin
            n_s1_w = 17'h10000 - {1'b0, n_s1_h6[15:0]};
        end else begin
            n_s1_w = {1'b0, n_s1_h6[15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_ts  <= n_s1_ts;
            r_s1_lig <= i_lightness;
            r_s1_sec <= t_sector'(n_s1_h6[18:16]);
            r_s1_w   <= n_s1_w;
            r_s1_alp <= i_alpha_in;
        end
    end

    // ---------------- stage 2: first quotient estimates ----------------
    logic [NW-1:0]  n_s2_num;
    logic [F:0]     n_s2_q0;
    logic [R0W-1:0] n_s2_r0;
    logic [LAW-1:0] n_s2_lnum;
    logic [F:0]     n_s2_lq0;
    logic [LRW-1:0] n_s2_lr0;

    logic [F:0]     r_s2_q0;
    logic [R0W-1:0] r_s2_r0;
    logic [F:0]     r_s2_lq0;
    logic [LRW-1:0] r_s2_lr0;
    t_sector        r_s2_sec;
    logic [16:0]    r_s2_w;
    logic [15:0]    r_s2_alp;

    always_comb begin
        // 2^32 = DEN + DEN_GAP, so num = q0*DEN + (lo + q0*DEN_GAP)
        n_s2_num = (NW'(r_s1_ts) << F) + NW'(DEN_HALF);
        n_s2_q0  = n_s2_num[NW-1:32];
        n_s2_r0  = R0W'(n_s2_num[31:0]) + (R0W'(n_s2_q0) << 17) - R0W'(n_s2_q0);
        // 2^16 = 65535 + 1
        n_s2_lnum = (LAW'(r_s1_lig) << F) + LAW'(IO_HALF);
        n_s2_lq0  = n_s2_lnum[LAW-1:16];
        n_s2_lr0  = LRW'(n_s2_lnum[15:0]) + LRW'(n_s2_lq0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s2_q0  <= n_s2_q0;
            r_s2_r0  <= n_s2_r0;
            r_s2_lq0 <= n_s2_lq0;
            r_s2_lr0 <= n_s2_lr0;
            r_s2_sec <= r_s1_sec;
            r_s2_w   <= r_s1_w;
            r_s2_alp <= r_s1_alp;
        end
    end

    // ---------------- stage 3: second estimate ----------------
    logic [Q1W-1:0]  n_s3_q1;
    logic [32:0]     n_s3_r1;
    logic [LQ1W-1:0] n_s3_lq1;
    logic [16:0]     n_s3_lr1;

    logic [F:0]  r_s3_q;
    logic [32:0] r_s3_r1;
    logic [F:0]  r_s3_lq;
    logic [16:0] r_s3_lr1;
    t_sector     r_s3_sec;
    logic [16:0] r_s3_w;
    logic [15:0] r_s3_alp;

    always_comb begin
        n_s3_q1  = r_s2_r0[R0W-1:32];
        n_s3_r1  = {1'b0, r_s2_r0[31:0]} + (33'(n_s3_q1) << 17) - 33'(n_s3_q1);
        n_s3_lq1 = r_s2_lr0[LRW-1:16];
        n_s3_lr1 = {1'b0, r_s2_lr0[15:0]} + 17'(n_s3_lq1);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s3_q   <= (F+1)'(r_s2_q0) + (F+1)'(n_s3_q1);
            r_s3_r1  <= n_s3_r1;
            r_s3_lq  <= (F+1)'(r_s2_lq0) + (F+1)'(n_s3_lq1);
            r_s3_lr1 <= n_s3_lr1;
            r_s3_sec <= r_s2_sec;
            r_s3_w   <= r_s2_w;
            r_s3_alp <= r_s2_alp;
        end
    end

    // ---------------- stage 4: final correction ----------------
    logic [F:0]  r_s4_cq;
    logic [F:0]  r_s4_lq;
    t_sector     r_s4_sec;
    logic [16:0] r_s4_w;
    logic [15:0] r_s4_alp;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s4_cq  <= r_s3_q + (F+1)'(r_s3_r1 >= DEN);
            r_s4_lq  <= r_s3_lq + (F+1)'(r_s3_lr1 >= {1'b0, IO_ONE});
            r_s4_sec <= r_s3_sec;
            r_s4_w   <= r_s3_w;
            r_s4_alp <= r_s3_alp;
        end
    end

    // ---------------- stage 5: x component, offset ----------------
    logic [XPW-1:0]       n_s5_xp;
    logic signed [CW-1:0] n_s5_m2;

    logic [F:0]           r_s5_xq;
    logic [F:0]           r_s5_cq;
    logic signed [CW-1:0] r_s5_m2;
    t_sector              r_s5_sec;
    logic [15:0]          r_s5_alp;

    always_comb begin
        n_s5_xp = XPW'(r_s4_cq) * XPW'(r_s4_w) + XPW'(17'h08000);
        n_s5_m2 = signed'(CW'(r_s4_lq) << 1) - signed'(CW'(r_s4_cq));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s5_xq  <= n_s5_xp[F+16:16];
            r_s5_cq  <= r_s4_cq;
            r_s5_m2  <= n_s5_m2;
            r_s5_sec <= r_s4_sec;
            r_s5_alp <= r_s4_alp;
        end
    end

    // ---------------- stage 6: sector placement ----------------
    logic signed [CW-1:0] n_s6_c2;
    logic signed [CW-1:0] n_s6_x2;
    logic signed [CW-1:0] n_s6_r;
    logic signed [CW-1:0] n_s6_g;
    logic signed [CW-1:0] n_s6_b;

    logic signed [CW-1:0] r_s6_r;
    logic signed [CW-1:0] r_s6_g;
    logic signed [CW-1:0] r_s6_b;
    logic [15:0]          r_s6_alp;

    always_comb begin
        n_s6_c2 = signed'(CW'(r_s5_cq) << 1);
        n_s6_x2 = signed'(CW'(r_s5_xq) << 1);
        n_s6_r  = r_s5_m2;
        n_s6_g  = r_s5_m2;
        n_s6_b  = r_s5_m2;
        case (r_s5_sec)
            SEC_RED_YEL: begin
                n_s6_r = r_s5_m2 + n_s6_c2;
                n_s6_g = r_s5_m2 + n_s6_x2;
            end
            SEC_YEL_GRN: begin
                n_s6_r = r_s5_m2 + n_s6_x2;
                n_s6_g = r_s5_m2 + n_s6_c2;
            end
            SEC_GRN_CYN: begin
                n_s6_g = r_s5_m2 + n_s6_c2;
                n_s6_b = r_s5_m2 + n_s6_x2;
            end
            SEC_CYN_BLU: begin
                n_s6_g = r_s5_m2 + n_s6_x2;
                n_s6_b = r_s5_m2 + n_s6_c2;
            end
            SEC_BLU_MAG: begin
                n_s6_r = r_s5_m2 + n_s6_x2;
                n_s6_b = r_s5_m2 + n_s6_c2;
            end
            default: begin
                n_s6_r = r_s5_m2 + n_s6_c2;
                n_s6_b = r_s5_m2 + n_s6_x2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_s6_r   <= n_s6_r;
            r_s6_g   <= n_s6_g;
            r_s6_b   <= n_s6_b;
            r_s6_alp <= r_s5_alp;
        end
    end

    // ---------------- stage 7: scale to 16 bits, output registers ----------------
    logic [15:0] r_s7_red;
    logic [15:0] r_s7_green;
    logic [15:0] r_s7_blue;
    logic [15:0] r_s7_alp;

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_s7_red   <= to_channel(r_s6_r);
            r_s7_green <= to_channel(r_s6_g);
            r_s7_blue  <= to_channel(r_s6_b);
            r_s7_alp   <= r_s6_alp;
        end
    end

    assign o_red       = r_s7_red;
    assign o_green     = r_s7_green;
    assign o_blue      = r_s7_blue;
    assign o_alpha_out = r_s7_alp;

endmodule

### bench/hsla_to_rgba_core_tb.sv
// Self-checking bench for hsla_to_rgba_core: directed corner colors, sector edges,
// random streams under several idle mixes and a long output hold.
// Depends on hsl2rgb_pkg and hsla_to_rgba_core from src.
`timescale 1ns / 1ps

module hsla_to_rgba_core_tb;
    import hsl2rgb_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH   = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_COUNT = 410;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } rgba_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_stall      = 1'b0;
    logic [15:0] i_hue        = '0;
    logic [15:0] i_saturation = '0;
    logic [15:0] i_lightness  = '0;
    logic [15:0] i_alpha_in   = '0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_red;
    logic [15:0] o_green;
    logic [15:0] o_blue;
    logic [15:0] o_alpha_out;

    rgba_t rgba_pending[$];
    int    n_errors      = 0;
    int    n_sent        = 0;
    int    n_checked     = 0;
    int    quiet_cycles  = 0;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    logic  hold_active   = 1'b0;
    event  hold_go;

    hsla_to_rgba_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .i_alpha_in   (i_alpha_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha_out  (o_alpha_out)
    );

    always #4 i_clk = ~i_clk;

    // Channel value held with FRAC+1 fraction bits, scaled back to 0..65535
    function automatic logic [15:0] scale_channel(input longint v2);
        longint unsigned r;
        if (v2 <= 0) begin
            return 16'd0;
        end
        r = v2;
        r = (r * 65535 + (64'd1 << FRAC)) >> (FRAC + 1);
        if (r > 65535) begin
            r = 65535;
        end
        return r[15:0];
    endfunction

    function automatic rgba_t convert_hsla(input logic [15:0] hue, input logic [15:0] sat,
                                           input logic [15:0] lig, input logic [15:0] alp);
        longint unsigned hv, sv, lv, den, ldist, span, c_q, l_q, x_q, h6, f, w;
        longint          m2, c2, x2, r2, g2, b2;
        logic [2:0]      sec_bits;
        t_sector         sector;
        rgba_t           res;
        hv  = hue;
        sv  = sat;
        lv  = lig;
        den = DEN;
        ldist = (2 * lv >= 65535) ? (2 * lv - 65535) : (65535 - 2 * lv);
        span  = (ldist >= 65535) ? 0 : (65535 - ldist);
        c_q  = (((span * sv) << FRAC) + den / 2) / den;
        l_q  = ((lv << FRAC) + 32767) / 65535;
        h6       = hv * 6;
        sec_bits = h6[18:16];
        sector   = t_sector'(sec_bits);
        f        = h6 & 64'hFFFF;
        w        = sec_bits[0] ? (65536 - f) : f;
        x_q      = (c_q * w + 32768) >> 16;
        m2 = longint'(2 * l_q) - longint'(c_q);
        c2 = 2 * longint'(c_q);
        x2 = 2 * longint'(x_q);
        case (sector)
            SEC_RED_YEL: begin r2 = c2; g2 = x2; b2 = 0;  end
            SEC_YEL_GRN: begin r2 = x2; g2 = c2; b2 = 0;  end
            SEC_GRN_CYN: begin r2 = 0;  g2 = c2; b2 = x2; end
            SEC_CYN_BLU: begin r2 = 0;  g2 = x2; b2 = c2; end
            SEC_BLU_MAG: begin r2 = x2; g2 = 0;  b2 = c2; end
            default:     begin r2 = c2; g2 = 0;  b2 = x2; end
        endcase
        res.red   = scale_channel(m2 + r2);
        res.green = scale_channel(m2 + g2);
        res.blue  = scale_channel(m2 + b2);
        res.alpha = alp;
        return res;
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF + 16'($urandom_range(2));
            default: return 16'($urandom);
        endcase
    endfunction

    // Drives one request and returns on the edge that takes it; valid stays high
    task automatic send_request(input logic [15:0] hue, input logic [15:0] sat,
                                input logic [15:0] lig, input logic [15:0] alp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_lightness  <= lig;
        i_alpha_in   <= alp;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        rgba_pending.push_back(convert_hsla(hue, sat, lig, alp));
        n_sent++;
    endtask

    // Receiver stall, with the long hold-off overriding the random pattern
    always @(posedge i_clk) begin
        i_stall <= hold_active || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        rgba_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rgba_pending.size() == 0) begin
                $display("%0t: result with nothing pending: r=%h g=%h b=%h a=%h",
                         $time, o_red, o_green, o_blue, o_alpha_out);
                n_errors++;
            end else begin
                want = rgba_pending.pop_front();
                n_checked++;
                if (o_red !== want.red) begin
                    $display("%0t: red expected %h got %h", $time, want.red, o_red);
                    n_errors++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green expected %h got %h", $time, want.green, o_green);
                    n_errors++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue expected %h got %h", $time, want.blue, o_blue);
                    n_errors++;
                end
                if (o_alpha_out !== want.alpha) begin
                    $display("%0t: alpha expected %h got %h", $time, want.alpha, o_alpha_out);
                    n_errors++;
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("[hsla_to_rgba_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Black, white, gray, full saturation at the lightness extremes and midpoint,
    // and lightness values where the channel rounds just below zero or above one
    task automatic test_corner_colors();
        send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'h1234, 16'h0000, 16'h8000, 16'hA5A5);
        send_request(16'h0000, 16'hFFFF, 16'h0000, 16'h5A5A);
        send_request(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_request(16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFFE);
        send_request(16'h0000, 16'hFFFF, 16'h8000, 16'h8000);
        send_request(16'h5555, 16'hFFFF, 16'h0001, 16'h7FFF);
        send_request(16'hAAAA, 16'hFFFF, 16'h0002, 16'h0000);
        send_request(16'h2000, 16'hFFFF, 16'hFFFE, 16'hFFFF);
        send_request(16'hFFFF, 16'h0001, 16'h4000, 16'h1111);
    endtask

    // Middle of every sector, then hues on and next to each sector edge but hue zero
    task automatic test_sector_edges();
        logic [15:0] edges[6] = '{16'd0, 16'd10923, 16'd21846, 16'd32768,
                                  16'd43691, 16'd54614};
        for (int k = 0; k < 6; k++) begin
            send_request(16'(k * 10923 + 5461), 16'hFFFF, 16'h8000, 16'hC0DE);
        end
        for (int k = 1; k < 6; k++) begin
            send_request(edges[k], 16'hFFFF, 16'h8000, 16'(k));
            send_request(edges[k] - 16'd1, 16'hC000, 16'h6000, 16'(k));
        end
    endtask

    task automatic test_random_stream(input int idle_pct, input int hold_pct, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        repeat (count) begin
            send_request(rand_field(), rand_field(), rand_field(), rand_field());
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_go;
        repeat (40) begin
            send_request(rand_field(), rand_field(), rand_field(), rand_field());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_colors();
        test_sector_edges();
        test_random_stream(0, 0, RANDOM_COUNT);
        test_random_stream(53, 0, RANDOM_COUNT);
        test_random_stream(0, 53, RANDOM_COUNT);
        test_random_stream(13, 13, RANDOM_COUNT);
        test_output_hold();
        test_random_stream(0, 0, 20);

        i_valid <= 1'b0;
        while (rgba_pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);

        $display("Sent %0d colors (corners, sector edges, four idle mixes, %0d-cycle hold);",
                 n_sent, HOLD_CYCLES);
        $display("checked %0d results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && rgba_pending.size() == 0) begin
            $display("[hsla_to_rgba_core] OK");
        end else begin
            $display("[hsla_to_rgba_core] ERROR");
        end
        $finish;
    end

endmodule
